### design/lpr_pkg.sv
// Shared constants and types for the page frame replacer.
package lpr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int FC_W   = 4;
  localparam int CMP_W  = (CNT_W > FC_W) ? CNT_W : FC_W;
  localparam int MISS_W = 32;
  localparam int FIDX_W = 3;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = CFG_IDX_W'(1);

  localparam logic [FC_W-1:0] FC_RESET = FC_W'(8);

  localparam logic ACT_REF   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } lpr_state_t;

  // One frame as seen through the scan read port.
  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     rank;
    logic [PAGE_BITS-1:0] page;
  } lpr_entry_t;

  // Table update issued once per item.
  typedef struct packed {
    logic                 clr;
    logic                 load;
    logic                 touch;
    logic                 from_empty;
    logic [IDX_W-1:0]     slot;
    logic [IDX_W-1:0]     old_rank;
    logic [PAGE_BITS-1:0] page;
  } lpr_upd_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     slot;
    logic                 evicted;
    logic [PAGE_BITS-1:0] ev_page;
    logic [MISS_W-1:0]    miss_total;
  } lpr_res_t;

endpackage

### design/lpr_if.sv
// Channel interfaces: page reference input, result output, config write.
interface lpr_in_if;
  import lpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [PAGE_BITS-1:0] page_id;
  modport source (output valid, output action, output page_id, input ready);
  modport sink   (input valid, input action, input page_id, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [MISS_W-1:0]    miss_total;
  modport source (output valid, output hit, output frame_index, output evicted,
                  output evicted_page, output miss_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted,
                  input evicted_page, input miss_total, output ready);
endinterface

interface lpr_cfg_if;
  import lpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/lpr_table.sv
// Frame table: page, valid and age rank per frame, one read port, touch update.
module lpr_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lpr_pkg::IDX_W-1:0] rd_idx,
  output lpr_pkg::lpr_entry_t      rd_entry,
  input  lpr_pkg::lpr_upd_t        upd
);
  import lpr_pkg::*;

  logic [PAGE_BITS-1:0] page_r  [MAX_FRAMES];
  logic [IDX_W-1:0]     rank_r  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r;

  assign rd_entry.valid = valid_r[rd_idx];
  assign rd_entry.rank  = rank_r[rd_idx];
  assign rd_entry.page  = page_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n || upd.clr) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
        page_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (upd.touch) begin
          if (IDX_W'(i) == upd.slot) begin
            valid_r[i] <= 1'b1;
            rank_r[i]  <= '0;
          end else if (valid_r[i] && (upd.from_empty || rank_r[i] < upd.old_rank)) begin
            // younger than the touched frame: ages by one
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
        if (upd.load && IDX_W'(i) == upd.slot) begin
          page_r[i] <= upd.page;
        end
      end
    end
  end

endmodule

### design/lpr_seq.sv
// Sequencer: scans active frames one per cycle with a shared compare unit.
module lpr_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [lpr_pkg::PAGE_BITS-1:0] in_page,
  input  logic [lpr_pkg::IDX_W-1:0] last_idx,
  input  logic                      policy,
  input  logic                      out_hold,
  output logic [lpr_pkg::IDX_W-1:0] rd_idx,
  input  lpr_pkg::lpr_entry_t       rd_entry,
  output lpr_pkg::lpr_upd_t         upd,
  output logic                      done,
  output lpr_pkg::lpr_res_t         res
);
  import lpr_pkg::*;

  lpr_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 clr_r, clr_nxt;
  logic                 hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic                 empty_found_r, empty_found_nxt;
  logic [IDX_W-1:0]     empty_slot_r, empty_slot_nxt;
  logic [IDX_W-1:0]     best_slot_r, best_slot_nxt;
  logic [IDX_W-1:0]     best_rank_r, best_rank_nxt;
  logic [PAGE_BITS-1:0] best_page_r, best_page_nxt;
  logic [MISS_W-1:0]    miss_r, miss_nxt;
  logic [MISS_W-1:0]    miss_inc;

  assign in_ready = (state_r == S_IDLE);
  assign rd_idx   = idx_r;
  assign miss_inc = (miss_r == '1) ? miss_r : miss_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      miss_r  <= '0;
    end else begin
      state_r <= state_nxt;
      miss_r  <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    page_r        <= page_nxt;
    clr_r         <= clr_nxt;
    hit_found_r   <= hit_found_nxt;
    hit_slot_r    <= hit_slot_nxt;
    hit_rank_r    <= hit_rank_nxt;
    empty_found_r <= empty_found_nxt;
    empty_slot_r  <= empty_slot_nxt;
    best_slot_r   <= best_slot_nxt;
    best_rank_r   <= best_rank_nxt;
    best_page_r   <= best_page_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    page_nxt        = page_r;
    clr_nxt         = clr_r;
    hit_found_nxt   = hit_found_r;
    hit_slot_nxt    = hit_slot_r;
    hit_rank_nxt    = hit_rank_r;
    empty_found_nxt = empty_found_r;
    empty_slot_nxt  = empty_slot_r;
    best_slot_nxt   = best_slot_r;
    best_rank_nxt   = best_rank_r;
    best_page_nxt   = best_page_r;
    miss_nxt        = miss_r;
    done            = 1'b0;
    upd             = '0;
    res             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          page_nxt        = in_page;
          clr_nxt         = (in_action == ACT_CLEAR);
          idx_nxt         = '0;
          hit_found_nxt   = 1'b0;
          empty_found_nxt = 1'b0;
          state_nxt       = (in_action == ACT_CLEAR) ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!hit_found_r && rd_entry.valid && rd_entry.page == page_r) begin
          hit_found_nxt = 1'b1;
          hit_slot_nxt  = idx_r;
          hit_rank_nxt  = rd_entry.rank;
        end
        if (!empty_found_r && !rd_entry.valid) begin
          empty_found_nxt = 1'b1;
          empty_slot_nxt  = idx_r;
        end
        // oldest candidate; only used when every active frame is valid
        if (idx_r == '0 || rd_entry.rank > best_rank_r) begin
          best_slot_nxt = idx_r;
          best_rank_nxt = rd_entry.rank;
          best_page_nxt = rd_entry.page;
        end
        if (idx_r == last_idx) begin
          state_nxt = S_UPDATE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_UPDATE: begin
        if (!out_hold) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
          priority if (clr_r) begin
            upd.clr  = 1'b1;
            miss_nxt = '0;
          end else if (hit_found_r) begin
            res.hit      = 1'b1;
            res.slot     = hit_slot_r;
            upd.touch    = (policy == POL_LRU);
            upd.slot     = hit_slot_r;
            upd.old_rank = hit_rank_r;
          end else if (empty_found_r) begin
            miss_nxt       = miss_inc;
            res.slot       = empty_slot_r;
            upd.load       = 1'b1;
            upd.touch      = 1'b1;
            upd.from_empty = 1'b1;
            upd.slot       = empty_slot_r;
            upd.page       = page_r;
          end else begin
            miss_nxt     = miss_inc;
            res.slot     = best_slot_r;
            res.evicted  = 1'b1;
            res.ev_page  = best_page_r;
            upd.load     = 1'b1;
            upd.touch    = 1'b1;
            upd.slot     = best_slot_r;
            upd.old_rank = best_rank_r;
            upd.page     = page_r;
          end
          res.miss_total = miss_nxt;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !(res.hit && res.evicted))
    else $error("hit and eviction in one result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= last_idx))
    else $error("scan index past last active frame");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (done && clr_r) |-> (res.miss_total == '0 && !res.hit && !upd.touch))
    else $error("clear item produced a nonzero result");

  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

### design/fifo_lru_page_frame_replacer_unit.sv
// Top level: config registers, frame table, scan sequencer and output register.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   action, page_id
//  out_ch   out  valid/ready   hit, frame_index, evicted, evicted_page, miss_total
//  cfg_ch   in   valid/ready   index, data (frame_count, policy_mode)
//
// A page reference is accepted, then scans the n active frames in turn, n the active
// frame count (1..MAX_FRAMES), through the single frame compare unit, then updates.
// A clear goes straight from accept to its update.
// Reset empties every frame and zeroes the miss count; config resets to 8 / FIFO.
// The output register holds a result until taken; the next item is accepted
// meanwhile and its update cycle waits while that register is still full.
module fifo_lru_page_frame_replacer_unit (
  input  logic      clk,
  input  logic      rst_n,
  lpr_in_if.sink    in_ch,
  lpr_out_if.source out_ch,
  lpr_cfg_if.sink   cfg_ch
);
  import lpr_pkg::*;

  logic [FC_W-1:0]      frame_count_r;
  logic                 policy_r;
  logic [IDX_W-1:0]     last_idx;
  logic [CMP_W-1:0]     fc_ext;
  logic                 out_valid_r;
  lpr_res_t             out_res_r;
  logic                 out_hold;
  logic [IDX_W-1:0]     rd_idx;
  lpr_entry_t           rd_entry;
  lpr_upd_t             upd;
  logic                 done;
  lpr_res_t             res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_RESET;
      policy_r      <= POL_FIFO;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FRAME_COUNT: frame_count_r <= cfg_ch.data[FC_W-1:0];
        CFG_POLICY:      policy_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // active frame count clamped to 1..MAX_FRAMES, as a last scan index
  assign fc_ext = CMP_W'(frame_count_r);
  always_comb begin
    priority if (fc_ext == '0) begin
      last_idx = '0;
    end else if (fc_ext > CMP_W'(MAX_FRAMES)) begin
      last_idx = IDX_W'(MAX_FRAMES - 1);
    end else begin
      last_idx = IDX_W'(fc_ext - 1'b1);
    end
  end

  assign out_hold = out_valid_r && !out_ch.ready;

  lpr_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .upd      (upd)
  );

  lpr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_page   (in_ch.page_id),
    .last_idx  (last_idx),
    .policy    (policy_r),
    .out_hold  (out_hold),
    .rd_idx    (rd_idx),
    .rd_entry  (rd_entry),
    .upd       (upd),
    .done      (done),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_res_r.hit;
  assign out_ch.frame_index  = FIDX_W'(out_res_r.slot);
  assign out_ch.evicted      = out_res_r.evicted;
  assign out_ch.evicted_page = out_res_r.ev_page;
  assign out_ch.miss_total   = out_res_r.miss_total;

endmodule

### verif/fifo_lru_page_frame_replacer_unit_test.sv
// Testbench for the page frame replacer: directed and random traffic against a local predictor.
module fifo_lru_page_frame_replacer_unit_test;
  import lpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = MAX_FRAMES + 4;

  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame;
    logic                 evicted;
    logic [PAGE_BITS-1:0] ev_page;
    logic [MISS_W-1:0]    misses;
  } page_res_t;

  logic clk;
  logic rst_n;

  lpr_in_if  in_ch();
  lpr_out_if out_ch();
  lpr_cfg_if cfg_ch();

  fifo_lru_page_frame_replacer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Frame table mirror
  logic [PAGE_BITS-1:0] fr_page [MAX_FRAMES];
  logic                 fr_valid[MAX_FRAMES];
  int                   fr_rank [MAX_FRAMES];
  logic [MISS_W-1:0]    miss_count;
  logic [FC_W-1:0]      fc_reg;
  logic                 pol_reg;

  page_res_t pending_results[$];
  page_res_t want_res;

  int fail_count;
  int cycle_count;
  int items_sent;
  int results_seen;
  int hit_count;
  int evict_count;
  int clear_count;
  int cfg_writes;
  int burst_left;

  // receiver stall pattern state
  int stall_tick;
  int stall_mode;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog: no completion after %0d cycles", CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_failure(string msg);
    fail_count++;
    $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [MISS_W-1:0] got, logic [MISS_W-1:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d field %s: got %0h, expected %0h",
                             results_seen, name, got, want));
  endtask

  function automatic void empty_table();
    int i;
    for (i = 0; i < MAX_FRAMES; i++) begin
      fr_page[i]  = '0;
      fr_valid[i] = 1'b0;
      fr_rank[i]  = 0;
    end
    miss_count = '0;
  endfunction

  // Frame f becomes youngest; every valid frame younger than it ages by one.
  function automatic void promote_frame(int f, int old_rank);
    int i;
    for (i = 0; i < MAX_FRAMES; i++)
      if (i != f && fr_valid[i] && fr_rank[i] < old_rank)
        fr_rank[i]++;
    fr_valid[f] = 1'b1;
    fr_rank[f]  = 0;
  endfunction

  function automatic page_res_t resolve_reference(logic act, logic [PAGE_BITS-1:0] pg);
    page_res_t r;
    int n, i, slot, best;
    bit found;
    r = '0;
    n = (fc_reg == 0) ? 1 : ((fc_reg > MAX_FRAMES) ? MAX_FRAMES : int'(fc_reg));
    if (act == ACT_CLEAR) begin
      empty_table();
      clear_count++;
      return r;
    end
    found = 1'b0;
    slot  = 0;
    // lowest matching active frame wins
    for (i = 0; i < n && !found; i++)
      if (fr_valid[i] && fr_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    if (found) begin
      r.hit = 1'b1;
      hit_count++;
      if (pol_reg == POL_LRU)
        promote_frame(slot, fr_rank[slot]);
    end else begin
      if (miss_count != '1)
        miss_count++;
      for (i = 0; i < n && !found; i++)
        if (!fr_valid[i]) begin
          slot  = i;
          found = 1'b1;
        end
      if (found) begin
        fr_page[slot] = pg;
        promote_frame(slot, MAX_FRAMES);
      end else begin
        best = 0;
        for (i = 1; i < n; i++)
          if (fr_rank[i] > fr_rank[best])
            best = i;
        slot      = best;
        r.evicted = 1'b1;
        r.ev_page = fr_page[slot];
        evict_count++;
        fr_page[slot] = pg;
        promote_frame(slot, fr_rank[slot]);
      end
    end
    r.frame  = FIDX_W'(slot);
    r.misses = miss_count;
    return r;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          note_failure("result arrived with no item outstanding");
        end else begin
          want_res = pending_results.pop_front();
          check_field("hit", MISS_W'(out_ch.hit), MISS_W'(want_res.hit));
          check_field("frame_index", MISS_W'(out_ch.frame_index), MISS_W'(want_res.frame));
          check_field("evicted", MISS_W'(out_ch.evicted), MISS_W'(want_res.evicted));
          check_field("evicted_page", MISS_W'(out_ch.evicted_page),
                      MISS_W'(want_res.ev_page));
          check_field("miss_total", out_ch.miss_total, want_res.misses);
        end
        results_seen++;
      end
      stall_tick++;
      if (stall_tick % 256 == 0)
        stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) >= 3);
        2: out_ch.ready <= ((stall_tick % 7) >= 3);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(4, 14);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Burst pacing: valid stays up within a burst, drops for the gap after it.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(logic act, logic [PAGE_BITS-1:0] pg);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.page_id <= pg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(resolve_reference(act, pg));
    items_sent++;
    pace_sender();
  endtask

  // Sender holds off until every outstanding item has produced its result.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_FRAME_COUNT)
      fc_reg = FC_W'(val);
    else if (idx == CFG_POLICY)
      pol_reg = val[0];
    cfg_writes++;
  endtask

  // Reset defaults: 8 frames, FIFO. Hits must not refresh insertion order.
  task automatic test_fifo_defaults();
    int k;
    send_item(ACT_REF, 16'h0000);
    send_item(ACT_REF, 16'hFFFF);
    send_item(ACT_REF, 16'h0000);
    send_item(ACT_REF, 16'hFFFF);
    for (k = 0; k < 6; k++)
      send_item(ACT_REF, PAGE_BITS'(1) << k);
    send_item(ACT_REF, 16'hAAAA);
    send_item(ACT_REF, 16'h0000);
  endtask

  task automatic test_lru_order();
    write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(3));
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_LRU));
    send_item(ACT_CLEAR, 16'h5555);
    send_item(ACT_REF, 16'h1234);
    send_item(ACT_REF, 16'h00FF);
    send_item(ACT_REF, 16'hFF00);
    send_item(ACT_REF, 16'h1234);
    send_item(ACT_REF, 16'h8001);
    send_item(ACT_REF, 16'h00FF);
  endtask

  // Zero frames acts as one; shrinking leaves duplicates behind, lowest frame wins.
  task automatic test_frame_count_limits();
    write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(0));
    send_item(ACT_REF, 16'h5A5A);
    send_item(ACT_REF, 16'h8001);
    write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(15));
    write_reg(CFG_IDX_W'(15), CFG_DATA_W'(15));
    write_reg(CFG_IDX_W'(2), CFG_DATA_W'(0));
    send_item(ACT_REF, 16'h8001);
  endtask

  task automatic test_clear_restart();
    send_item(ACT_CLEAR, 16'hFFFF);
    send_item(ACT_REF, 16'h7FFF);
    send_item(ACT_REF, 16'h7FFF);
  endtask

  task automatic test_random_traffic();
    logic [PAGE_BITS-1:0]  pool[12];
    logic [CFG_DATA_W-1:0] fc_pick;
    logic                  pol_pick;
    int pool_n, phase, k, roll;
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin fc_pick = CFG_DATA_W'(1);  pol_pick = POL_FIFO; end
        1: begin fc_pick = CFG_DATA_W'(8);  pol_pick = POL_LRU;  end
        2: begin fc_pick = CFG_DATA_W'(15); pol_pick = POL_FIFO; end
        3: begin fc_pick = CFG_DATA_W'(0);  pol_pick = POL_LRU;  end
        default: begin
          fc_pick  = CFG_DATA_W'($urandom_range(0, 15));
          pol_pick = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(CFG_FRAME_COUNT, fc_pick);
      // upper data bits are don't-care for the policy register
      write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), pol_pick});
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
      pool_n = $urandom_range(2, 12);
      for (k = 0; k < pool_n; k++)
        pool[k] = PAGE_BITS'($urandom);
      for (k = 0; k < 95; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          send_item(ACT_CLEAR, PAGE_BITS'($urandom));
        else if (roll < 13)
          send_item(ACT_REF, PAGE_BITS'($urandom));
        else
          send_item(ACT_REF, pool[$urandom_range(0, pool_n - 1)]);
        if ($urandom_range(0, 199) == 0)
          wait_idle();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_REF;
    in_ch.page_id = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_FRAME_COUNT;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    fc_reg        = FC_RESET;
    pol_reg       = POL_FIFO;
    burst_left    = 1;
    empty_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fifo_defaults();
    test_lru_order();
    test_frame_count_limits();
    test_clear_restart();
    test_random_traffic();

    wait_idle();
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d items: %0d hits, %0d evictions, %0d clears; %0d results checked.",
             items_sent, hit_count, evict_count, clear_count, results_seen);
    $display("Used %0d register writes: frame counts 0, 1, 8, 15 and random, both policies.",
             cfg_writes);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
